@@ rtl/rtba_pkg.sv @@
// Shared types and codes for the region table bump allocator.
package rtba_pkg;

    typedef enum logic [1:0] {
        KIND_ALLOC   = 2'd0,
        KIND_RELEASE = 2'd1,
        KIND_BUMP    = 2'd2,
        KIND_LOOKUP  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_REL,
        ST_BUMP,
        ST_LOOK,
        ST_FAIL
    } state_t;

    localparam logic [7:0] CFG_HEAP_BASE = 8'd0;
    localparam logic [7:0] CFG_REGIONS   = 8'd1;

    localparam logic [3:0] CLASS_FREE        = 4'd0;
    localparam logic [3:0] CLASS_UNCOMMITTED = 4'd9;

    localparam logic [2:0] PHASE_UNCOMMITTED = 3'd0;
    localparam logic [2:0] PHASE_FREE        = 3'd1;
    localparam logic [2:0] PHASE_ACTIVE      = 3'd2;

    localparam int WORD_BITS  = 32;
    localparam int WORD_SHIFT = 5;
    localparam int OFS_W      = 19;

endpackage

@@ rtl/rtba_ram.sv @@
// Simple dual-port synchronous RAM, one write port and one registered read port.
module rtba_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8
) (
    input  logic                                  aclk,
    input  logic                                  wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic                                  rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/region_table_bump_allocator.sv @@
// Top level of the region table bump allocator.
// Usage:
//   s_* carries one request beat (allocate region, release, bump allocate,
//   lookup); m_* returns exactly one result beat per request, in order. cfg_*
//   writes heap_base (index 0) or regions_in_use (index 1); other indexes are
//   dropped. Idle-only writes are up to the user. cfg_ready is always high.
// Storage: region entries {class, phase, fill offset} sit in one RAM, and a
//   free-region bitmap in 32-bit words sits in a second RAM; both have a
//   registered read. Requests are handled one at a time.
// Release, bump, lookup and a failed range check read the RAM at the
//   accepting edge, then update and load the result register. Allocate
//   scans one bitmap word per cycle until a free region is found, reading
//   at least 1 and at most ceil(count / 32) words. A new request is taken
//   in the cycle after a result is loaded.
// Reset: a clearing pass writes every entry as uncommitted and marks every
//   region free in the bitmap; s_ready stays low until it ends.
// Stall: the result register holds while m_ready is low; the next request
//   is still accepted and runs up to its result, which waits for the slot.
module region_table_bump_allocator #(
    parameter int REGION_SLOTS = 256,
    parameter int REGION_SHIFT = 18
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [3:0]  s_new_region_class,
    input  logic [7:0]  s_target_region,
    input  logic [31:0] s_request_size,
    input  logic [63:0] s_lookup_address,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_success,
    output logic [7:0]  m_region_number,
    output logic [63:0] m_result_address,
    output logic [3:0]  m_region_class,
    output logic [2:0]  m_region_phase,
    output logic [18:0] m_fill_offset,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    import rtba_pkg::*;

    localparam int IDX_W  = $clog2(REGION_SLOTS);
    localparam int CUR_W  = REGION_SHIFT + 1;
    localparam int HI_W   = 64 - REGION_SHIFT;
    localparam int ENT_W  = 4 + 3 + CUR_W;
    localparam int WORDS  = (REGION_SLOTS + WORD_BITS - 1) / WORD_BITS;
    localparam int WA_W   = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int CNT_W  = ($clog2(REGION_SLOTS + 1) > 9) ? $clog2(REGION_SLOTS + 1) : 9;

    state_t state_reg, state_next;

    logic [IDX_W-1:0]  clr_reg, clr_next;
    logic [63:0]       heap_base_reg, heap_base_next;
    logic [8:0]        riu_reg, riu_next;

    logic [3:0]        req_cls_reg, req_cls_next;
    logic [CNT_W-1:0]  req_idx_reg, req_idx_next;
    logic [32:0]       req_rnd_reg, req_rnd_next;
    logic [HI_W-1:0]   req_bhi_reg, req_bhi_next;
    logic [WA_W-1:0]   scan_w_reg, scan_w_next;

    logic              m_valid_reg, m_valid_next;
    logic              m_success_reg, m_success_next;
    logic [7:0]        m_number_reg, m_number_next;
    logic [63:0]       m_addr_reg, m_addr_next;
    logic [3:0]        m_class_reg, m_class_next;
    logic [2:0]        m_phase_reg, m_phase_next;
    logic [OFS_W-1:0]  m_ofs_reg, m_ofs_next;

    logic              ent_wr_en, ent_rd_en;
    logic [IDX_W-1:0]  ent_wr_addr, ent_rd_addr;
    logic [ENT_W-1:0]  ent_wr_data, ent_rd_data;
    logic              av_wr_en, av_rd_en;
    logic [WA_W-1:0]   av_wr_addr, av_rd_addr;
    logic [WORD_BITS-1:0] av_wr_data, av_rd_data;

    rtba_ram #(.DEPTH(REGION_SLOTS), .WIDTH(ENT_W)) u_ent_ram (
        .aclk    (aclk),
        .wr_en   (ent_wr_en),
        .wr_addr (ent_wr_addr),
        .wr_data (ent_wr_data),
        .rd_en   (ent_rd_en),
        .rd_addr (ent_rd_addr),
        .rd_data (ent_rd_data)
    );

    rtba_ram #(.DEPTH(WORDS), .WIDTH(WORD_BITS)) u_avail_ram (
        .aclk    (aclk),
        .wr_en   (av_wr_en),
        .wr_addr (av_wr_addr),
        .wr_data (av_wr_data),
        .rd_en   (av_rd_en),
        .rd_addr (av_rd_addr),
        .rd_data (av_rd_data)
    );

    // request decode
    logic             accept, fire, cfg_fire;
    logic [CNT_W-1:0] riu_ext, eff_cnt, tgt_ext;
    logic             tgt_ok;
    logic [HI_W-1:0]  base_hi, addr_hi, look_diff;
    logic             look_hit;
    logic [32:0]      rnd;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;
    assign fire      = !m_valid_reg || m_ready;
    assign cfg_fire  = cfg_valid && cfg_ready;

    assign riu_ext   = CNT_W'(riu_reg);
    assign eff_cnt   = (riu_ext > CNT_W'(REGION_SLOTS)) ? CNT_W'(REGION_SLOTS) : riu_ext;
    assign tgt_ext   = CNT_W'(s_target_region);
    assign tgt_ok    = tgt_ext < eff_cnt;
    assign base_hi   = heap_base_reg[63:REGION_SHIFT];
    assign addr_hi   = s_lookup_address[63:REGION_SHIFT];
    assign look_diff = addr_hi - base_hi;
    assign look_hit  = (addr_hi >= base_hi) && (look_diff < HI_W'(eff_cnt));
    assign rnd       = ({1'b0, s_request_size} + 33'd7) & ~33'd7;

    // bitmap scan
    logic [CNT_W-1:0]     scan_base, scan_rem, alloc_idx;
    logic [WORD_BITS-1:0] scan_mask, scan_cand;
    logic                 scan_found, scan_last;
    logic [WORD_SHIFT-1:0] scan_pick;

    assign scan_base  = CNT_W'({scan_w_reg, {WORD_SHIFT{1'b0}}});
    assign scan_rem   = eff_cnt - scan_base;
    assign scan_mask  = (scan_rem >= CNT_W'(WORD_BITS)) ? '1 :
                        ((WORD_BITS'(1) << scan_rem[WORD_SHIFT-1:0]) - WORD_BITS'(1));
    assign scan_cand  = av_rd_data & scan_mask;
    assign scan_found = |scan_cand;
    assign scan_last  = scan_rem <= CNT_W'(WORD_BITS);
    assign alloc_idx  = scan_base | CNT_W'(scan_pick);

    always_comb begin
        scan_pick = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (scan_cand[b]) begin
                scan_pick = WORD_SHIFT'(b);
            end
        end
    end

    // entry fields
    logic [3:0]       ent_cls;
    logic [2:0]       ent_ph;
    logic [CUR_W-1:0] ent_cur;
    logic [33:0]      bump_sum;
    logic             bump_ok;

    assign ent_cls  = ent_rd_data[ENT_W-1 -: 4];
    assign ent_ph   = ent_rd_data[CUR_W +: 3];
    assign ent_cur  = ent_rd_data[CUR_W-1:0];
    assign bump_sum = 34'(ent_cur) + 34'(req_rnd_reg);
    assign bump_ok  = bump_sum <= (34'd1 << REGION_SHIFT);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_reg == IDX_W'(REGION_SLOTS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    unique case (kind_t'(s_kind))
                        KIND_ALLOC:   state_next = ST_SCAN;
                        KIND_RELEASE: state_next = tgt_ok ? ST_REL : ST_FAIL;
                        KIND_BUMP:    state_next = tgt_ok ? ST_BUMP : ST_FAIL;
                        KIND_LOOKUP:  state_next = look_hit ? ST_LOOK : ST_FAIL;
                        default:      state_next = ST_FAIL;
                    endcase
                end
            end
            ST_SCAN: begin
                if ((scan_found || scan_last) && fire) begin
                    state_next = ST_IDLE;
                end
            end
            ST_REL, ST_BUMP, ST_LOOK, ST_FAIL: begin
                if (fire) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath, RAM commands and result
    always_comb begin
        logic load;

        load           = 1'b0;
        clr_next       = clr_reg;
        heap_base_next = heap_base_reg;
        riu_next       = riu_reg;
        req_cls_next   = req_cls_reg;
        req_idx_next   = req_idx_reg;
        req_rnd_next   = req_rnd_reg;
        req_bhi_next   = req_bhi_reg;
        scan_w_next    = scan_w_reg;

        m_success_next = 1'b0;
        m_number_next  = '0;
        m_addr_next    = '0;
        m_class_next   = '0;
        m_phase_next   = '0;
        m_ofs_next     = '0;

        ent_wr_en   = 1'b0;
        ent_wr_addr = req_idx_reg[IDX_W-1:0];
        ent_wr_data = '0;
        ent_rd_en   = 1'b0;
        ent_rd_addr = tgt_ext[IDX_W-1:0];
        av_wr_en    = 1'b0;
        av_wr_addr  = scan_w_reg;
        av_wr_data  = '0;
        av_rd_en    = 1'b0;
        av_rd_addr  = '0;

        if (cfg_fire) begin
            if (cfg_index == CFG_HEAP_BASE) begin
                heap_base_next = cfg_data;
            end else if (cfg_index == CFG_REGIONS) begin
                riu_next = cfg_data[8:0];
            end
        end

        unique case (state_reg)
            ST_CLEAR: begin
                clr_next    = clr_reg + 1'b1;
                ent_wr_en   = 1'b1;
                ent_wr_addr = clr_reg;
                ent_wr_data = {CLASS_UNCOMMITTED, PHASE_UNCOMMITTED, {CUR_W{1'b0}}};
                av_wr_en    = CNT_W'(clr_reg) < CNT_W'(WORDS);
                av_wr_addr  = WA_W'(CNT_W'(clr_reg));
                av_wr_data  = '1;
            end
            ST_IDLE: begin
                if (accept) begin
                    req_cls_next  = s_new_region_class;
                    req_rnd_next  = rnd;
                    scan_w_next   = '0;
                    if (kind_t'(s_kind) == KIND_LOOKUP) begin
                        req_idx_next = look_diff[CNT_W-1:0];
                        req_bhi_next = addr_hi;
                        ent_rd_addr  = look_diff[IDX_W-1:0];
                    end else begin
                        req_idx_next = tgt_ext;
                        req_bhi_next = base_hi + HI_W'(s_target_region);
                    end
                    ent_rd_en  = (kind_t'(s_kind) == KIND_BUMP) ||
                                 (kind_t'(s_kind) == KIND_LOOKUP);
                    av_rd_en   = (kind_t'(s_kind) == KIND_ALLOC) ||
                                 (kind_t'(s_kind) == KIND_RELEASE);
                    av_rd_addr = (kind_t'(s_kind) == KIND_ALLOC) ? '0 :
                                 WA_W'(tgt_ext >> WORD_SHIFT);
                end
            end
            ST_SCAN: begin
                if (scan_found) begin
                    if (fire) begin
                        load           = 1'b1;
                        ent_wr_en      = 1'b1;
                        ent_wr_addr    = alloc_idx[IDX_W-1:0];
                        ent_wr_data    = {req_cls_reg, PHASE_ACTIVE, {CUR_W{1'b0}}};
                        av_wr_en       = 1'b1;
                        av_wr_addr     = scan_w_reg;
                        av_wr_data     = av_rd_data & ~(WORD_BITS'(1) << scan_pick);
                        m_success_next = 1'b1;
                        m_number_next  = alloc_idx[7:0];
                        m_addr_next    = {base_hi + HI_W'(alloc_idx), {REGION_SHIFT{1'b0}}};
                        m_class_next   = req_cls_reg;
                        m_phase_next   = PHASE_ACTIVE;
                    end
                end else if (scan_last) begin
                    load = fire;
                end else begin
                    scan_w_next = scan_w_reg + 1'b1;
                    av_rd_en    = 1'b1;
                    av_rd_addr  = scan_w_reg + 1'b1;
                end
            end
            ST_REL: begin
                if (fire) begin
                    load           = 1'b1;
                    ent_wr_en      = 1'b1;
                    ent_wr_data    = {CLASS_FREE, PHASE_FREE, {CUR_W{1'b0}}};
                    av_wr_en       = 1'b1;
                    av_wr_addr     = WA_W'(req_idx_reg >> WORD_SHIFT);
                    av_wr_data     = av_rd_data |
                                     (WORD_BITS'(1) << req_idx_reg[WORD_SHIFT-1:0]);
                    m_success_next = 1'b1;
                    m_number_next  = req_idx_reg[7:0];
                    m_class_next   = CLASS_FREE;
                    m_phase_next   = PHASE_FREE;
                end
            end
            ST_BUMP: begin
                if (fire) begin
                    load = 1'b1;
                    if (bump_ok) begin
                        ent_wr_en      = 1'b1;
                        ent_wr_data    = {ent_cls, ent_ph, bump_sum[CUR_W-1:0]};
                        m_success_next = 1'b1;
                        m_number_next  = req_idx_reg[7:0];
                        m_addr_next    = {req_bhi_reg + HI_W'(ent_cur[REGION_SHIFT]),
                                          ent_cur[REGION_SHIFT-1:0]};
                        m_class_next   = ent_cls;
                        m_phase_next   = ent_ph;
                        m_ofs_next     = OFS_W'(bump_sum[CUR_W-1:0]);
                    end
                end
            end
            ST_LOOK: begin
                if (fire) begin
                    load           = 1'b1;
                    m_success_next = 1'b1;
                    m_number_next  = req_idx_reg[7:0];
                    m_addr_next    = {req_bhi_reg, {REGION_SHIFT{1'b0}}};
                    m_class_next   = ent_cls;
                    m_phase_next   = ent_ph;
                    m_ofs_next     = OFS_W'(ent_cur);
                end
            end
            ST_FAIL: begin
                load = fire;
            end
            default: begin
                load = 1'b0;
            end
        endcase

        m_valid_next = load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
        if (!load) begin
            m_success_next = m_success_reg;
            m_number_next  = m_number_reg;
            m_addr_next    = m_addr_reg;
            m_class_next   = m_class_reg;
            m_phase_next   = m_phase_reg;
            m_ofs_next     = m_ofs_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            heap_base_reg <= '0;
            riu_reg       <= 9'd256;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            heap_base_reg <= heap_base_next;
            riu_reg       <= riu_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_cls_reg   <= req_cls_next;
        req_idx_reg   <= req_idx_next;
        req_rnd_reg   <= req_rnd_next;
        req_bhi_reg   <= req_bhi_next;
        scan_w_reg    <= scan_w_next;
        m_success_reg <= m_success_next;
        m_number_reg  <= m_number_next;
        m_addr_reg    <= m_addr_next;
        m_class_reg   <= m_class_next;
        m_phase_reg   <= m_phase_next;
        m_ofs_reg     <= m_ofs_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_success        = m_success_reg;
    assign m_region_number  = m_number_reg;
    assign m_result_address = m_addr_reg;
    assign m_region_class   = m_class_reg;
    assign m_region_phase   = m_phase_reg;
    assign m_fill_offset    = m_ofs_reg;

endmodule
